@@ hdl/skls_pkg.sv @@
// Shared types and constants for the streaming k-th largest selector.
package skls_pkg;

  // Heap capacity and the widths that follow from it.
  localparam int MAX_KEEP = 2048;
  localparam int ADDR_W   = $clog2(MAX_KEEP);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int CFG_W    = 12;
  localparam int DATA_W   = 32;

  // Configuration register indexes.
  localparam int REG_KEEP_COUNT = 0;

  typedef logic signed [DATA_W-1:0] value_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start_up;
    logic start_dn;
    logic rd_parent;
    logic rd_children;
    logic wr_key;
    logic up_move;
    logic dn_move;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic insert;
    logic replace;
    logic pos_zero;
    logic parent_le;
    logic dn_stop;
    logic last;
    logic out_busy;
    cnt_t kept_total;
  } status_t;

endpackage

@@ hdl/skls_ctrl.sv @@
// Controller state machine that sequences heap insertion, replacement and result output.
module skls_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  skls_pkg::status_t st,
  output skls_pkg::cmd_t    cmd,
  output skls_pkg::state_t  state
);
  import skls_pkg::*;

  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (st.insert) begin
          state_next = ST_UP_RD;
        end else if (st.replace) begin
          state_next = ST_DN_RD;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_UP_RD: begin
        state_next = st.pos_zero ? ST_FINISH : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        state_next = st.parent_le ? ST_FINISH : ST_UP_RD;
      end
      ST_DN_RD: begin
        state_next = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        state_next = st.dn_stop ? ST_FINISH : ST_DN_RD;
      end
      ST_FINISH: begin
        if (!st.last || !st.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_DECIDE: begin
        cmd.start_up = st.insert;
        cmd.start_dn = !st.insert && st.replace;
      end
      ST_UP_RD: begin
        cmd.wr_key    = st.pos_zero;
        cmd.rd_parent = !st.pos_zero;
      end
      ST_UP_CMP: begin
        cmd.wr_key  = st.parent_le;
        cmd.up_move = !st.parent_le;
      end
      ST_DN_RD: begin
        cmd.rd_children = 1'b1;
      end
      ST_DN_CMP: begin
        cmd.wr_key  = st.dn_stop;
        cmd.dn_move = !st.dn_stop;
      end
      ST_FINISH: begin
        cmd.emit = st.last && !st.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/skls_dpath.sv @@
// Datapath: heap memory, sift position, kept count, root copy and output register.
module skls_dpath (
  input  logic                clk,
  input  logic                rst,
  input  skls_pkg::cmd_t      cmd,
  output skls_pkg::status_t   st,
  input  skls_pkg::cnt_t      k_eff,
  input  logic [31:0]         s_tdata,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output logic                m_tuser
);
  import skls_pkg::*;

  value_t heap_mem [MAX_KEEP];

  value_t key;
  logic   last;
  addr_t  pos;
  cnt_t   kept_total;
  value_t root;
  value_t rd_a;
  value_t rd_b;
  value_t kth_largest;
  logic   full_res;

  logic [ADDR_W+1:0] left_idx;
  logic [ADDR_W+1:0] right_idx;
  logic [ADDR_W+1:0] cnt_ext;
  logic              left_ok;
  logic              right_ok;
  logic              take_left;
  logic              take_right;
  value_t            best_val;
  addr_t             parent;
  addr_t             rd_addr_a;
  logic              wr_en;
  value_t            wr_data;
  addr_t             next_pos;

  // Child and parent indexes of the current hole.
  assign left_idx  = {1'b0, pos, 1'b1};
  assign right_idx = left_idx + {{(ADDR_W+1){1'b0}}, 1'b1};
  assign cnt_ext   = {1'b0, kept_total};
  assign parent    = (pos - addr_t'(1)) >> 1;

  // Pick the smaller in-range child that beats the sifted key.
  always_comb begin
    left_ok    = left_idx < cnt_ext;
    right_ok   = right_idx < cnt_ext;
    take_left  = left_ok && (rd_a < key);
    best_val   = take_left ? rd_a : key;
    take_right = right_ok && (rd_b < best_val);
  end

  // Write port selection.
  always_comb begin
    wr_en    = cmd.wr_key || cmd.up_move || cmd.dn_move;
    wr_data  = key;
    next_pos = pos;
    if (cmd.up_move) begin
      wr_data  = rd_a;
      next_pos = parent;
    end else if (cmd.dn_move) begin
      wr_data  = take_right ? rd_b : rd_a;
      next_pos = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    end
  end

  assign rd_addr_a = cmd.rd_parent ? parent : left_idx[ADDR_W-1:0];

  // Heap memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) heap_mem[pos] <= wr_data;
    if (cmd.rd_parent || cmd.rd_children) begin
      rd_a <= heap_mem[rd_addr_a];
      rd_b <= heap_mem[right_idx[ADDR_W-1:0]];
    end
  end

  // Input word capture, hole position and root copy.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key  <= value_t'(s_tdata);
      last <= s_tlast;
    end
    if (cmd.start_up) begin
      pos <= kept_total[ADDR_W-1:0];
    end else if (cmd.start_dn) begin
      pos <= '0;
    end else if (cmd.up_move || cmd.dn_move) begin
      pos <= next_pos;
    end
    if (wr_en && (pos == '0)) root <= wr_data;
  end

  // Kept count: grows on insertion, clears when a result is loaded into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_total <= '0;
    end else if (cmd.emit) begin
      kept_total <= '0;
    end else if (cmd.start_up) begin
      kept_total <= kept_total + cnt_t'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kth_largest <= root;
      full_res    <= kept_total >= k_eff;
    end
  end

  assign m_tdata = kth_largest;
  assign m_tuser = full_res;

  // Status toward the controller.
  always_comb begin
    st            = '0;
    st.insert     = kept_total < k_eff;
    st.replace    = key > root;
    st.pos_zero   = pos == '0;
    st.parent_le  = rd_a <= key;
    st.dn_stop    = !take_left && !take_right;
    st.last       = last;
    st.out_busy   = m_tvalid && !m_tready;
    st.kept_total = kept_total;
  end

endmodule

@@ hdl/streaming_kth_largest_selector_top.sv @@
// Top level: configuration port, effective k, controller and datapath.
// A word is either dropped or sifted through the heap one level at a time, each level being
// a memory read, then a compare and move; the heap has 12 levels.
// A new word is accepted only once the previous word has finished; a result is registered after
// the final word of a set is processed, later while the previous result still waits for acceptance.
// Synchronous reset sets k to 1 and the kept count to 0; heap memory is not cleared.
module streaming_kth_largest_selector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] kth_largest
  output logic        m_tuser,   // [0] full_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import skls_pkg::*;

  logic [CFG_W-1:0] keep_count;
  cnt_t             k_eff;
  cmd_t             cmd;
  status_t          st;
  state_t           state;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = 32'(paddr[2]) == REG_KEEP_COUNT;

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= CFG_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      keep_count <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = reg_sel ? 32'(keep_count) : '0;

  // Zero acts as one; values above capacity act as capacity.
  always_comb begin
    int unsigned kc;
    kc = 32'(keep_count);
    if (kc == 0) kc = 1;
    if (kc > MAX_KEEP) kc = MAX_KEEP;
    k_eff = CNT_W'(kc);
  end

  skls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd),
    .state    (state)
  );

  skls_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .k_eff    (k_eff),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // The kept count never exceeds the heap capacity.
  assert property (@(posedge clk) disable iff (rst) st.kept_total <= CNT_W'(MAX_KEEP))
    else $error("kept count above heap capacity");

  // A new result only follows the finishing step of a word.
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finishing step");

  // Sending a result restarts the set with an empty heap.
  assert property (@(posedge clk) disable iff (rst) $rose(m_tvalid) |-> st.kept_total == '0)
    else $error("kept count not cleared after a result");

endmodule

@@ dv/tb_streaming_kth_largest_selector_top.sv @@
// Self-checking testbench for the streaming k-th largest selector top level.
module tb_streaming_kth_largest_selector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import skls_pkg::*;

  localparam int          IDLE_LIMIT    = 2000;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          RANDOM_WORDS  = 1850;
  localparam int          MAX_SET       = 60;
  localparam int          PLAN_ROWS     = 30;
  localparam logic [2:0]  KEEP_ADDR     = 3'(4 * REG_KEEP_COUNT);

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  // One row of the directed plan: a word to send or a k to write.
  typedef struct {
    row_kind_t   kind;
    logic [31:0] data;
    logic        last;
    logic        typed;
    logic [31:0] exp_kth;
    logic        exp_full;
  } plan_row_t;

  typedef struct {
    value_t kth;
    logic   full;
  } kth_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: current k register and the kept values, ascending.
  logic [CFG_W-1:0] keep_reg = CFG_W'(1);
  value_t           kept_q[$];
  kth_res_t         kth_due_q[$];
  int unsigned      mismatches = 0;
  int unsigned      idle_cycles = 0;
  bit               quiet = 1'b0;
  plan_row_t        plan [PLAN_ROWS];

  streaming_kth_largest_selector_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Effective k: zero acts as one, and k is capped at the heap capacity.
  function automatic int unsigned k_now();
    int unsigned k;
    k = 32'(keep_reg);
    if (k == 0) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    return k;
  endfunction

  function automatic void keep_insert(value_t v);
    int i;
    i = 0;
    while (i < kept_q.size() && kept_q[i] < v) i++;
    kept_q.insert(i, v);
  endfunction

  // Takes one word into the kept set and forms the result on the last word.
  function automatic void absorb_word(value_t v, logic last, output bit made,
                                      output kth_res_t res);
    int unsigned k;
    k = k_now();
    made = 1'b0;
    res.kth = '0;
    res.full = 1'b0;
    if (kept_q.size() < k) begin
      keep_insert(v);
    end else if (v > kept_q[0]) begin
      void'(kept_q.pop_front());
      keep_insert(v);
    end
    if (last) begin
      made = 1'b1;
      res.kth = kept_q[0];
      res.full = (kept_q.size() >= k);
      kept_q.delete();
    end
  endfunction

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic logic [31:0] draw_value(int unsigned mode);
    int t;
    case (mode)
      0: begin
        return $urandom;
      end
      1: begin
        t = int'($urandom_range(0, 8)) - 4;
        return 32'(t);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Mostly small k, sometimes medium, now and then the edges of the range.
  function automatic logic [31:0] pick_keep();
    int unsigned r;
    logic [CFG_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      case ($urandom_range(0, 5))
        0: k = '0;
        1: k = CFG_W'(1);
        2: k = CFG_W'(MAX_KEEP);
        3: k = CFG_W'(MAX_KEEP + 1);
        4: k = '1;
        default: k = CFG_W'(2);
      endcase
    end else if (r < 16) begin
      k = CFG_W'($urandom_range(17, 80));
    end else begin
      k = CFG_W'($urandom_range(1, 16));
    end
    return ($urandom & 32'hFFFF_F000) | 32'(k);
  endfunction

  // Send one word after a random gap and record what it should produce.
  task automatic send_word(logic [31:0] v, logic last, bit typed, kth_res_t typed_res);
    int unsigned gap;
    bit made;
    kth_res_t res;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= v;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    absorb_word(value_t'(v), last, made, res);
    if (made) kth_due_q.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Let the block drain: every result delivered and any sift finished.
  task automatic settle_block();
    s_tvalid <= 1'b0;
    while (kth_due_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write k, then read it back.
  task automatic write_keep(logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= KEEP_ADDR;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    keep_reg = data[CFG_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(keep_reg)) report_mismatch("keep_count readback", 32'(keep_reg), prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stimulus: directed plan first, then random phases.
  initial begin : stimulus
    kth_res_t tres;
    int unsigned sent;
    int unsigned nsets;
    int unsigned len;
    int unsigned mode;
    bit open_end;

    plan = '{
      '{ROW_WORD, 32'd5,          1'b1, 1'b1, 32'd5,          1'b1},
      '{ROW_WORD, 32'h7FFF_FFFF,  1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'h8000_0000,  1'b1, 1'b1, 32'h7FFF_FFFF,  1'b1},
      '{ROW_WORD, 32'h8000_0000,  1'b1, 1'b1, 32'h8000_0000,  1'b1},
      '{ROW_CFG,  32'd0,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'hFFFF_FFF9,  1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'hFFFF_FFF9,  1'b1, 1'b1, 32'hFFFF_FFF9,  1'b1},
      '{ROW_CFG,  32'd3,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd10,         1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd20,         1'b1, 1'b1, 32'd10,         1'b0},
      '{ROW_WORD, 32'd4,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd4,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd4,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd4,          1'b1, 1'b1, 32'd4,          1'b1},
      '{ROW_WORD, 32'd9,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd2,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd8,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd3,          1'b1, 1'b0, 32'd0,          1'b0},
      '{ROW_CFG,  32'hFFFF_FFFF,  1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd1,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd2,          1'b1, 1'b1, 32'd1,          1'b0},
      '{ROW_CFG,  32'd5,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd1,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd2,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd3,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd4,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd5,          1'b0, 1'b0, 32'd0,          1'b0},
      // k drops to two in the middle of a set that already holds five.
      '{ROW_CFG,  32'd2,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd0,          1'b0, 1'b0, 32'd0,          1'b0},
      '{ROW_WORD, 32'd7,          1'b1, 1'b0, 32'd0,          1'b0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle_block();
        write_keep(plan[i].data);
      end else begin
        tres.kth = value_t'(plan[i].exp_kth);
        tres.full = plan[i].exp_full;
        send_word(plan[i].data, plan[i].last, plan[i].typed, tres);
      end
    end

    // Random phases; a phase may end inside a set so that k changes mid-set.
    tres.kth = '0;
    tres.full = 1'b0;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      settle_block();
      write_keep(pick_keep());
      quiet = ($urandom_range(0, 4) == 0);
      nsets = $urandom_range(1, 5);
      for (int s = 0; s < nsets; s++) begin
        len = $urandom_range(1, 2 * k_now() + 3);
        if (len > MAX_SET) len = $urandom_range(1, MAX_SET);
        mode = $urandom_range(0, 2);
        open_end = (s == nsets - 1) && ($urandom_range(0, 5) == 0);
        for (int j = 0; j < len; j++) begin
          send_word(draw_value(mode), (j == len - 1) && !open_end, 1'b0, tres);
          sent++;
        end
      end
    end

    settle_block();
    if (mismatches == 0) begin
      $display("tb_streaming_kth_largest_selector_top: clean");
    end else begin
      $display("tb_streaming_kth_largest_selector_top: errors");
    end
    $finish;
  end

  // Result side: a random stall before taking each word.
  initial begin : drain
    int unsigned stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Compare every delivered result with the oldest expectation.
  always @(posedge clk) begin : result_check
    kth_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (kth_due_q.size() == 0) begin
        report_mismatch("unexpected word", 32'd0, m_tdata);
      end else begin
        want = kth_due_q.pop_front();
        if (m_tdata !== want.kth) report_mismatch("kth_largest", want.kth, m_tdata);
        if (m_tuser !== want.full) report_mismatch("full_res", 32'(want.full), 32'(m_tuser));
      end
    end
  end

  // Watchdog: too long with no handshake on any port ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_streaming_kth_largest_selector_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
